// ----- sv/itie_pkg.sv -----
// Package: shared constants, types and action codes for the interval table.
package itie_pkg;

  localparam int Depth  = 64;
  localparam int AddrW  = $clog2(Depth);
  localparam int CountW = AddrW + 1;
  localparam int BoundW = 16;
  localparam int EntryW = 2 * BoundW + 24 + 32;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_OPEN   = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_COLOR  = 3'd3,
    ACT_OPAC   = 3'd4,
    ACT_ACCEPT = 3'd5,
    ACT_CANCEL = 3'd6,
    ACT_READ   = 3'd7
  } action_t;

  localparam logic [2:0] REG_RED  = 3'd0;
  localparam logic [2:0] REG_GRN  = 3'd1;
  localparam logic [2:0] REG_BLU  = 3'd2;
  localparam logic [2:0] REG_OPAC = 3'd3;
  localparam logic [2:0] REG_GRAD = 3'd4;

  typedef struct packed {
    logic signed [BoundW-1:0] low;
    logic signed [BoundW-1:0] high;
    logic [23:0]              color;
    logic [31:0]              opac;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    entry_t            wdata;
    logic [AddrW-1:0]  raddr;
  } mem_req_t;

endpackage

// ----- sv/itie_mem.sv -----
// Entry memory: one write port, one registered read port.
module itie_mem (
  input  logic               clk,
  input  itie_pkg::mem_req_t req,
  output itie_pkg::entry_t   rdata
);
  import itie_pkg::*;

  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- sv/interval_table_insert_edit.sv -----
// Top level: interval table sequencer, config registers and output register.
//
//  channel   | dir | tdata fields (low bit first)
//  s_axis    | in  | action, range_low, range_high, entry_index, red, green, blue,
//            |     | opacity_level, gradient_level
//  m_axis    | out | edit_index, entry_total, error_flag, out_low, out_high,
//            |     | out_red, out_green, out_blue, out_opacity, out_gradient
//  cfg       | in  | wr_en, wr_index, wr_data (default attributes)
//
// One item at a time: s_axis_tready is high only while idle. Add scans the table
// with a read and a write back per entry (S_SCANRD, S_SCANWR), then opens the slot
// by moving entries up with a read and a write each (S_SHIFT, S_SHWR); delete moves
// the later entries down the same way (S_DELRD, S_DELWR). The single memory port
// sets this order of steps; m_axis_tready low holds the result in S_OUT. Reset (rst,
// synchronous) empties the table and closes any session.
module interval_table_insert_edit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action[2:0], range_low[18:3], range_high[34:19], entry_index[40:35],
  // red[48:41], green[56:49], blue[64:57], opacity[80:65], gradient[96:81]
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // edit_index[6:0], entry_total[13:7], error_flag[14], out_low[30:15],
  // out_high[46:31], red[54:47], green[62:55], blue[70:63], opacity[86:71],
  // gradient[102:87]
  output logic [103:0] m_axis_tdata,
  input  logic         wr_en,
  input  logic [2:0]   wr_index,
  input  logic [15:0]  wr_data
);
  import itie_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCANRD = 9'b000000010,
    S_SCANWR = 9'b000000100,
    S_SHIFT  = 9'b000001000,
    S_SHWR   = 9'b000010000,
    S_DELRD  = 9'b000100000,
    S_DELWR  = 9'b001000000,
    S_SHOW   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;

  // default attribute registers
  logic [7:0]  def_r, def_g, def_b;
  logic [15:0] def_o, def_gr;

  always_ff @(posedge clk) begin
    if (rst) begin
      def_r <= 8'hFF; def_g <= 8'hFF; def_b <= 8'hFF;
      def_o <= 16'hFFFF; def_gr <= 16'hFFFF;
    end else if (wr_en) begin
      case (wr_index)
        REG_RED:  def_r  <= wr_data[7:0];
        REG_GRN:  def_g  <= wr_data[7:0];
        REG_BLU:  def_b  <= wr_data[7:0];
        REG_OPAC: def_o  <= wr_data;
        REG_GRAD: def_gr <= wr_data;
        default: ;
      endcase
    end
  end

  // captured item
  action_t                  act;
  logic signed [BoundW-1:0] lo, hi;
  logic [AddrW-1:0]         idx;
  logic [23:0]              in_color;
  logic [31:0]              in_opac;

  // table control
  logic [CountW-1:0] count;
  logic              edit_on;
  logic [AddrW-1:0]  edit_pos;
  logic [23:0]       saved_color;
  logic [31:0]       saved_opac;

  // scan pointers: r read index, w write index, ins insertion point
  logic [CountW-1:0] r, w, ins;
  logic              stop;     // hit an entry fully right of the new range
  logic              show_rd;  // S_SHOW shows entry_index rather than edit_pos
  logic              opening;  // this item opened the session
  logic              err;

  // index of the incoming transfer and its range check
  logic [AddrW-1:0] in_idx;
  logic             idx_bad;
  assign in_idx  = s_axis_tdata[40:35];
  assign idx_bad = ({1'b0, in_idx} >= count);

  mem_req_t req;
  entry_t   rdata;

  itie_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

  entry_t new_e;
  assign new_e = '{low: lo, high: hi, color: {def_r, def_g, def_b},
                   opac: {def_o, def_gr}};

  // result register
  logic [6:0]  o_edit;
  logic [6:0]  o_total;
  logic        o_err;
  entry_t      o_e;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {1'b0, o_e.opac[15:0], o_e.opac[31:16], o_e.color[7:0],
                          o_e.color[15:8], o_e.color[23:16], o_e.high, o_e.low,
                          o_err, o_total, o_edit};

  // scan-time modified entry (add pass)
  entry_t mod_e;
  logic   keep, is_left, is_stop;
  always_comb begin
    mod_e   = rdata;
    keep    = 1'b1;
    is_left = 1'b0;
    is_stop = 1'b0;
    if (rdata.high <= lo) begin
      is_left = 1'b1;
    end else if (rdata.low < lo) begin
      mod_e.high = lo;
      is_left = 1'b1;
    end else if (hi <= rdata.low) begin
      is_stop = 1'b1;
    end else if (hi < rdata.high) begin
      mod_e.low = hi;
    end else begin
      keep = 1'b0;
    end
    if (stop) begin
      mod_e = rdata; keep = 1'b1; is_left = 1'b0; is_stop = 1'b0;
    end
  end

  // edited entry after set color, set opacity or cancel
  entry_t upd_e;
  always_comb begin
    upd_e = rdata;
    case (act)
      ACT_COLOR: upd_e.color = in_color;
      ACT_OPAC:  upd_e.opac  = in_opac;
      ACT_CANCEL: begin
        upd_e.color = saved_color;
        upd_e.opac  = saved_opac;
      end
      default: ;
    endcase
  end

  logic [AddrW-1:0] open_pos;
  assign open_pos = ({1'b0, idx} < count) ? idx : AddrW'(count - 1'b1);

  always_comb begin
    req = '0;
    req.wdata = mod_e;
    case (state)
      S_SCANRD: req.raddr = r[AddrW-1:0];
      S_SCANWR: begin
        req.we    = keep;
        req.waddr = w[AddrW-1:0];
      end
      S_SHIFT:  req.raddr = AddrW'(w - 1'b1);
      S_SHWR: begin
        if (w == ins) begin
          req.we = 1'b1; req.waddr = ins[AddrW-1:0]; req.wdata = new_e;
        end else begin
          req.we = 1'b1; req.waddr = w[AddrW-1:0]; req.wdata = rdata;
        end
      end
      S_DELRD:  req.raddr = AddrW'(r + 1'b1);
      S_DELWR: begin
        req.we = 1'b1; req.waddr = r[AddrW-1:0]; req.wdata = rdata;
      end
      S_SHOW: begin
        if (show_rd) req.raddr = idx;
        else if (act == ACT_OPEN && !edit_on) req.raddr = open_pos;
        else req.raddr = edit_pos;
      end
      S_OUT: begin
        // write the edited entry back while the result is loaded
        req.raddr = edit_pos;
        req.waddr = edit_pos;
        req.wdata = upd_e;
        req.we    = !m_axis_tvalid && edit_on &&
                    (act == ACT_COLOR || act == ACT_OPAC || act == ACT_CANCEL);
      end
      default:  req.raddr = edit_pos;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      edit_on <= 1'b0;
      edit_pos <= '0;
      saved_color <= '0;
      saved_opac  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            act      <= action_t'(s_axis_tdata[2:0]);
            lo       <= s_axis_tdata[18:3];
            hi       <= s_axis_tdata[34:19];
            idx      <= in_idx;
            in_color <= {s_axis_tdata[48:41], s_axis_tdata[56:49], s_axis_tdata[64:57]};
            in_opac  <= {s_axis_tdata[80:65], s_axis_tdata[96:81]};
            opening  <= 1'b0;
            case (action_t'(s_axis_tdata[2:0]))
              ACT_ADD: begin
                show_rd <= 1'b0;
                if (!edit_on && count < CountW'(Depth)) begin
                  err <= 1'b0;
                  r <= '0; w <= '0; ins <= '0; stop <= 1'b0;
                  if (count == '0) begin
                    count <= CountW'(1);
                    state <= S_SHIFT;
                  end else begin
                    state <= S_SCANRD;
                  end
                end else begin
                  err   <= !edit_on;   // full table
                  state <= S_SHOW;
                end
              end
              ACT_DELETE: begin
                show_rd <= 1'b0;
                if (!edit_on && !idx_bad) begin
                  err   <= 1'b0;
                  r     <= {1'b0, in_idx};
                  state <= ({1'b0, in_idx} + 1'b1 < count) ? S_DELRD : S_SHOW;
                  count <= count - 1'b1;
                end else begin
                  err   <= !edit_on;
                  state <= S_SHOW;
                end
              end
              ACT_READ: begin
                err     <= idx_bad;
                show_rd <= !idx_bad;
                state   <= S_SHOW;
              end
              default: begin
                err     <= 1'b0;
                show_rd <= 1'b0;
                state   <= S_SHOW;
              end
            endcase
          end
        end
        S_SCANRD: state <= S_SCANWR;
        S_SCANWR: begin
          if (is_stop) stop <= 1'b1;
          if (is_left) ins <= ins + 1'b1;
          if (keep) w <= w + 1'b1;
          r <= r + 1'b1;
          if (r + 1'b1 < count) begin
            state <= S_SCANRD;
          end else begin
            // kept entries plus the new one
            count <= w + CountW'(keep) + 1'b1;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: state <= S_SHWR;
        S_SHWR: begin
          if (w == ins) begin
            edit_on  <= 1'b1;
            edit_pos <= ins[AddrW-1:0];
            saved_color <= new_e.color;
            saved_opac  <= new_e.opac;
            state <= S_SHOW;
          end else begin
            w <= w - 1'b1;
            state <= S_SHIFT;
          end
        end
        S_DELRD: state <= S_DELWR;
        S_DELWR: begin
          r <= r + 1'b1;
          state <= (r + 2'd2 <= count) ? S_DELRD : S_SHOW;
        end
        S_SHOW: begin
          // read of the shown entry is issued here
          state <= S_OUT;
          case (act)
            ACT_OPEN: begin
              if (!edit_on) begin
                if (count == '0) err <= 1'b1;
                else begin
                  edit_on <= 1'b1; edit_pos <= open_pos; opening <= 1'b1;
                end
              end
            end
            ACT_ACCEPT: edit_on <= 1'b0;
            default: ;
          endcase
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            // rdata holds the entry read in S_SHOW
            if (opening) begin
              saved_color <= rdata.color;
              saved_opac  <= rdata.opac;
            end
            if (act == ACT_CANCEL) edit_on <= 1'b0;
            o_edit  <= edit_on && act != ACT_CANCEL ? {1'b0, edit_pos} : 7'h7F;
            o_total <= 7'(count);
            o_err   <= err;
            o_e     <= (show_rd || (edit_on && act != ACT_CANCEL)) ? upd_e : '0;
            m_axis_tvalid <= 1'b1;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
